[hdl/notification_fragmenter_assert.svh]
// ----------------------------------------------------------------------------
// notification fragmenter assertion macros
// shared concurrent assertion forms, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef NOTIFICATION_FRAGMENTER_ASSERT_SVH
`define NOTIFICATION_FRAGMENTER_ASSERT_SVH

// same-cycle implication
`define NFRAG_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NFRAG_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/nfrag_pkg.sv]
// ----------------------------------------------------------------------------
// nfrag_pkg
// item types, sequencer states and fixed constants of the fragmenter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfrag_pkg;

   localparam int LEN_W      = 12;
   localparam int MTU_W      = 10;
   localparam int PAYLOAD_W  = 9;
   localparam int DIVIDEND_W = 13;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [MTU_W-1:0] MTU_MIN      = 10'd23;
   localparam logic [MTU_W-1:0] MTU_MAX      = 10'd517;
   localparam logic [MTU_W-1:0] MTU_RESET    = 10'd23;
   localparam logic [MTU_W-1:0] RAW_OVERHEAD = 10'd3;
   localparam logic [MTU_W-1:0] HDR_OVERHEAD = 10'd7;
   localparam logic [7:0]       HASH_BYTE    = 8'h23;

   // header byte slots
   localparam logic [1:0] HDR_IDX_HASH0  = 2'd0;
   localparam logic [1:0] HDR_IDX_HASH1  = 2'd1;
   localparam logic [1:0] HDR_IDX_TOTAL  = 2'd2;
   localparam logic [1:0] HDR_IDX_NUMBER = 2'd3;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] message_length;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       header_byte;
      logic       packet_end;
      logic       message_end;
   } rsp_item_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_HDR  = 4'b0100,
      ST_DATA = 4'b1000
   } nfrag_state_type;

endpackage

[hdl/nfrag_div.sv]
// ----------------------------------------------------------------------------
// nfrag_div
// restoring serial divider, one quotient bit per cycle, chunk count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "notification_fragmenter_assert.svh"

module nfrag_div
   import nfrag_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [PAYLOAD_W-1:0]  divisor,
   output logic [7:0]            quotient,
   output div_status_type        status
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PAYLOAD_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [PAYLOAD_W-1:0]  dvs_ff, dvs_in;
   logic [PAYLOAD_W:0]    trial;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? PAYLOAD_W'(trial - {1'b0, dvs_ff}) : PAYLOAD_W'(trial);
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff[7:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `NFRAG_ASSERT_NXT(a_div_start_busy, start, busy_ff, "divider did not start")
   `NFRAG_ASSERT_IMP(a_div_done_idle, done_ff, !busy_ff, "divider done while busy")
   `NFRAG_ASSERT_IMP(a_div_rem_bound, busy_ff, rem_ff < dvs_ff, "partial remainder too large")

endmodule

[hdl/notification_fragmenter.sv]
// an accepted raw or mid-chunk byte goes via data_ff to the output register once that is free
// a byte that opens a chunk: its four header items are loaded first, then its data item
// the first byte of a cut message first waits for the 13 divider steps and takes the chunk count
// a new byte is taken only once the last is in the output register; a result stall holds the load
// reset: synchronous, active high; mtu back to 23, message state to start of message
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// notification_fragmenter
// cuts a byte stream message into notification packets with '#' chunk headers
// ----------------------------------------------------------------------------

`include "notification_fragmenter_assert.svh"

module notification_fragmenter
   import nfrag_pkg::*;
#(
   parameter int MAX_MESSAGE = 4080
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_item_type       req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_item_type       rsp_item,
   input  logic               csr_wr_en,
   input  logic [MTU_W-1:0]   csr_wr_data
);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MESSAGE);

   // sequencer and message state
   nfrag_state_type       state_ff, state_in;
   logic [MTU_W-1:0]      mtu_ff;
   logic [LEN_W-1:0]      pos_ff, pos_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  frag_ff, frag_in;
   logic [PAYLOAD_W-1:0]  payload_ff, payload_in;
   logic [7:0]            total_ff, total_in;
   logic [7:0]            chunk_ff, chunk_in;
   logic [PAYLOAD_W-1:0]  bic_ff, bic_in;
   logic [7:0]            data_ff, data_in;
   logic [1:0]            hdr_idx_ff, hdr_idx_in;

   // output register, parts the sequencer from the result side
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;
   logic                  can_load;

   // message-start setup
   logic [LEN_W-1:0]      len_fix;
   logic [MTU_W-1:0]      mtu_clamp;
   logic [PAYLOAD_W-1:0]  payload_new;
   logic                  start_frag;
   logic                  accept;

   // data byte flags
   logic                  last_msg;
   logic                  last_in_chunk;

   // chunk count divider
   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [7:0]            div_quotient;
   div_status_type        div_status;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign can_load = !rsp_valid_ff || !rsp_stall;

   // zero length acts as one byte, long messages saturate
   always_comb begin
      if (req_item.message_length == '0) begin
         len_fix = LEN_W'(1);
      end else if (req_item.message_length > MAX_LEN) begin
         len_fix = MAX_LEN;
      end else begin
         len_fix = req_item.message_length;
      end
   end

   // mtu outside the legal range is clamped at message start
   always_comb begin
      if (mtu_ff < MTU_MIN) begin
         mtu_clamp = MTU_MIN;
      end else if (mtu_ff > MTU_MAX) begin
         mtu_clamp = MTU_MAX;
      end else begin
         mtu_clamp = mtu_ff;
      end
   end

   assign payload_new  = PAYLOAD_W'(mtu_clamp - HDR_OVERHEAD);
   assign start_frag   = (len_fix > {{(LEN_W-MTU_W){1'b0}}, mtu_clamp - RAW_OVERHEAD});
   // ceiling divide: (len + payload - 1) / payload
   assign div_dividend = DIVIDEND_W'(len_fix) + DIVIDEND_W'(payload_new)
                         - DIVIDEND_W'(1);

   assign last_msg      = (DIVIDEND_W'(pos_ff) + DIVIDEND_W'(1)) >= DIVIDEND_W'(len_ff);
   assign last_in_chunk = ({1'b0, bic_ff} + 1'b1) >= {1'b0, payload_ff};

   nfrag_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (payload_new),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      frag_in      = frag_ff;
      payload_in   = payload_ff;
      total_in     = total_ff;
      chunk_in     = chunk_ff;
      bic_in       = bic_ff;
      data_in      = data_ff;
      hdr_idx_in   = hdr_idx_ff;
      div_start    = 1'b0;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               data_in    = req_item.data_byte;
               hdr_idx_in = HDR_IDX_HASH0;
               if (pos_ff == '0) begin
                  // first byte latches the message setup
                  len_in     = len_fix;
                  bic_in     = '0;
                  frag_in    = start_frag;
                  payload_in = start_frag ? payload_new : '0;
                  total_in   = '0;
                  chunk_in   = start_frag ? 8'd1 : 8'd0;
                  div_start  = start_frag;
                  state_in   = start_frag ? ST_DIV : ST_DATA;
               end else begin
                  state_in = (frag_ff && bic_ff == '0) ? ST_HDR : ST_DATA;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               total_in = div_quotient;
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            if (can_load) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.header_byte = 1'b1;
               rsp_item_in.packet_end  = 1'b0;
               rsp_item_in.message_end = 1'b0;
               case (hdr_idx_ff)
                  HDR_IDX_HASH0:  rsp_item_in.out_byte = HASH_BYTE;
                  HDR_IDX_HASH1:  rsp_item_in.out_byte = HASH_BYTE;
                  HDR_IDX_TOTAL:  rsp_item_in.out_byte = total_ff;
                  HDR_IDX_NUMBER: rsp_item_in.out_byte = chunk_ff;
                  default:        rsp_item_in.out_byte = HASH_BYTE;
               endcase
               hdr_idx_in = hdr_idx_ff + 1'b1;
               if (hdr_idx_ff == HDR_IDX_NUMBER) begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (can_load) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.out_byte    = data_ff;
               rsp_item_in.header_byte = 1'b0;
               rsp_item_in.packet_end  = last_msg || (frag_ff && last_in_chunk);
               rsp_item_in.message_end = last_msg;
               state_in                = ST_IDLE;
               if (last_msg) begin
                  pos_in = '0;
                  bic_in = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  if (frag_ff) begin
                     if (last_in_chunk) begin
                        bic_in   = '0;
                        chunk_in = chunk_ff + 1'b1;
                     end else begin
                        bic_in = bic_ff + 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mtu_ff       <= MTU_RESET;
         pos_ff       <= '0;
         len_ff       <= '0;
         frag_ff      <= 1'b0;
         payload_ff   <= '0;
         total_ff     <= '0;
         chunk_ff     <= '0;
         bic_ff       <= '0;
         hdr_idx_ff   <= HDR_IDX_HASH0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            mtu_ff <= csr_wr_data;
         end
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         frag_ff      <= frag_in;
         payload_ff   <= payload_in;
         total_ff     <= total_in;
         chunk_ff     <= chunk_in;
         bic_ff       <= bic_in;
         hdr_idx_ff   <= hdr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_ff     <= data_in;
      rsp_item_ff <= rsp_item_in;
   end

   // busy until the byte in hand is loaded into the output register
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `NFRAG_ASSERT_IMP(a_div_wait, state_ff == ST_DIV, div_status.busy || div_status.done, "waiting on idle divider")
   `NFRAG_ASSERT_IMP(a_hdr_no_end, rsp_valid_ff && rsp_item_ff.header_byte, !rsp_item_ff.packet_end && !rsp_item_ff.message_end, "header item marks an end")
   `NFRAG_ASSERT_IMP(a_msg_end_pkt, rsp_valid_ff && rsp_item_ff.message_end, rsp_item_ff.packet_end, "message end without packet end")
   `NFRAG_ASSERT_IMP(a_chunk_bound, frag_ff, bic_ff < payload_ff, "chunk position past chunk size")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the notification fragmenter: byte streams go in
// under random sender gaps and receiver stalls, and every packet byte that
// comes out is compared with an in-bench model of the chunking rules
// ----------------------------------------------------------------------------

module tb_top;
   import nfrag_pkg::*;

   localparam int CLK_HALF      = 4;
   localparam int MAX_MESSAGE   = 4080;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS  = 60;
   localparam int MAX_REPORTS   = 10;

   // receiver stall patterns
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // dut ports, all inputs known from time zero
   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_item_type     req_item    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_item_type     rsp_item;
   logic             csr_wr_en   = 1'b0;
   logic [MTU_W-1:0] csr_wr_data = '0;

   // shadow of the fragmenter state, reset values
   logic [MTU_W-1:0]     mtu_shadow  = MTU_RESET;
   logic [LEN_W-1:0]     msg_pos     = '0;
   logic [LEN_W-1:0]     msg_len     = '0;
   logic                 chunked     = 1'b0;
   logic [PAYLOAD_W-1:0] chunk_size  = '0;
   logic [PAYLOAD_W-1:0] chunk_fill  = '0;
   logic [7:0]           chunk_total = '0;
   logic [7:0]           chunk_no    = '0;

   // packet bytes still owed by the dut, oldest first
   rsp_item_type expected_bytes[$];

   int fail_count    = 0;
   int cycle_count   = 0;
   int items_sent    = 0;
   int burst_left    = 0;
   int hold_requests = 0;
   int holds_done    = 0;

   notification_fragmenter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #CLK_HALF clock = ~clock;

   // run limit, far above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // mtu as the block uses it at message start
   function automatic int clamp_mtu(input logic [MTU_W-1:0] value);
      if (value < MTU_MIN) return int'(MTU_MIN);
      if (value > MTU_MAX) return int'(MTU_MAX);
      return int'(value);
   endfunction

   // one accepted byte -> the packet bytes it produces
   function automatic void predict_packet_bytes(input req_item_type it);
      int   len;
      int   mtu;
      int   payload;
      logic last_msg;
      logic last_pkt;
      if (msg_pos == 0) begin
         // length is only looked at on the first byte of a message
         len = int'(it.message_length);
         if (len == 0) len = 1;
         if (len > MAX_MESSAGE) len = MAX_MESSAGE;
         mtu = clamp_mtu(mtu_shadow);
         msg_len    = LEN_W'(len);
         chunk_fill = '0;
         if (len > mtu - int'(RAW_OVERHEAD)) begin
            payload     = mtu - int'(HDR_OVERHEAD);
            chunked     = 1'b1;
            chunk_size  = PAYLOAD_W'(payload);
            chunk_total = 8'((len + payload - 1) / payload);
            chunk_no    = 8'd1;
         end else begin
            chunked     = 1'b0;
            chunk_size  = '0;
            chunk_total = '0;
            chunk_no    = '0;
         end
      end
      // chunk opens with '#', '#', count, number
      if (chunked && chunk_fill == 0) begin
         expected_bytes.push_back({HASH_BYTE, 1'b1, 1'b0, 1'b0});
         expected_bytes.push_back({HASH_BYTE, 1'b1, 1'b0, 1'b0});
         expected_bytes.push_back({chunk_total, 1'b1, 1'b0, 1'b0});
         expected_bytes.push_back({chunk_no, 1'b1, 1'b0, 1'b0});
      end
      last_msg = (int'(msg_pos) + 1) >= int'(msg_len);
      last_pkt = last_msg || (chunked && (int'(chunk_fill) + 1) >= int'(chunk_size));
      expected_bytes.push_back({it.data_byte, 1'b0, last_pkt, last_msg});
      if (last_msg) begin
         msg_pos    = '0;
         chunk_fill = '0;
      end else begin
         msg_pos = msg_pos + 1'b1;
         if (chunked) begin
            if ((int'(chunk_fill) + 1) >= int'(chunk_size)) begin
               chunk_fill = '0;
               chunk_no   = chunk_no + 1'b1;
            end else begin
               chunk_fill = chunk_fill + 1'b1;
            end
         end
      end
   endfunction

   // offer one item, in bursts with random gaps between them
   task automatic send_item(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item  <= it;
      burst_left--;
      // accepted at the first edge with stall low
      do @(posedge clock); while (req_stall);
      items_sent++;
      predict_packet_bytes(it);
   endtask

   // random message bytes; past the first byte the length field is sometimes junk
   task automatic send_bytes(input logic [LEN_W-1:0] len_field, input int count);
      req_item_type it;
      for (int i = 0; i < count; i++) begin
         it.data_byte = 8'($urandom_range(0, 255));
         if (msg_pos != 0 && $urandom_range(0, 3) == 0)
            it.message_length = LEN_W'($urandom_range(0, 4095));
         else
            it.message_length = len_field;
         send_item(it);
      end
   endtask

   // stop offering, wait for every owed byte, then let the pipe settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mtu(input logic [MTU_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      mtu_shadow = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // receiver: changing stall patterns, plus long hold-offs on request
   initial begin : stall_pattern
      stall_mode_type mode;
      int mode_left;
      int hold_left;
      int phase;
      mode      = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      phase     = 0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 80);
         end
         mode_left--;
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= (phase % 3 == 0);
            endcase
         end
      end
   end

   // every accepted packet byte against the oldest owed one
   always @(posedge clock) begin : check_bytes
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected packet byte: byte %02h hdr %0b pend %0b mend %0b",
                        rsp_item.out_byte, rsp_item.header_byte,
                        rsp_item.packet_end, rsp_item.message_end);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_item.out_byte !== want.out_byte ||
                rsp_item.header_byte !== want.header_byte ||
                rsp_item.packet_end !== want.packet_end ||
                rsp_item.message_end !== want.message_end) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("packet byte mismatch: expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                           want.out_byte, want.header_byte, want.packet_end,
                           want.message_end, rsp_item.out_byte, rsp_item.header_byte,
                           rsp_item.packet_end, rsp_item.message_end);
            end
         end
      end
   end

   // reset mtu: single bytes, zero length, a short raw message
   task automatic test_short_messages();
      req_item_type it;
      it.data_byte      = 8'h00;
      it.message_length = 12'd1;
      send_item(it);
      // zero length counts as a one-byte message
      it.data_byte      = 8'hFF;
      it.message_length = '0;
      send_item(it);
      send_bytes(12'd3, 3);
      wait_idle();
   endtask

   // 21 bytes at mtu 23 -> chunks of 16 and 5; mtu rewritten mid-message
   task automatic test_chunked_message();
      req_item_type it;
      send_bytes(12'd21, 10);
      wait_idle();
      // new mtu must not touch the message already running
      write_mtu(MTU_MAX);
      // length field changed mid-message, must be ignored
      it.data_byte      = 8'h5A;
      it.message_length = 12'hFFF;
      send_item(it);
      send_bytes(12'd21, 10);
      wait_idle();
   endtask

   // long receiver hold-off while the sender keeps pushing
   task automatic test_backpressure();
      // mtu 0 clamps to 23: 40 bytes in three chunks
      write_mtu('0);
      hold_requests++;
      send_bytes(12'd40, 40);
      wait_idle();
   endtask

   // random mtu per phase, mostly well-formed raw and chunked messages
   task automatic test_random_messages();
      int start;
      int eff;
      int len;
      int hi;
      int kind;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       write_mtu(MTU_W'($urandom_range(0, 22)));
            1:       write_mtu(MTU_W'($urandom_range(518, 1023)));
            2:       write_mtu(MTU_MAX);
            default: write_mtu(MTU_W'($urandom_range(23, 45)));
         endcase
         eff = clamp_mtu(mtu_shadow);
         repeat ($urandom_range(1, 3)) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
               len = 0;
            end else if (kind < 4 || eff > 60) begin
               // raw packet, up to the raw limit for small mtu
               hi  = (eff - 3 < 40) ? eff - 3 : 40;
               len = $urandom_range(1, hi);
            end else begin
               // just past the raw limit up to about three chunks
               hi  = eff - 2 + 2 * (eff - 7);
               if (hi > 64) hi = 64;
               len = $urandom_range(eff - 2, hi);
            end
            send_bytes(LEN_W'(len), (len == 0) ? 1 : len);
         end
         wait_idle();
      end
   endtask

   // length 4095 saturates to 4080: 8 chunks of 510, not 9; left open at the end
   task automatic test_length_saturation();
      write_mtu(10'h3FF);
      send_bytes(12'hFFF, 6);
      wait_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_short_messages();
      test_chunked_message();
      test_backpressure();
      test_random_messages();
      test_length_saturation();
      wait_idle();
      // anything still owed counts against the run
      fail_count += expected_bytes.size();
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[notification_fragmenter.f]
+incdir+hdl
hdl/nfrag_pkg.sv
hdl/nfrag_div.sv
hdl/notification_fragmenter.sv
dv/tb_top.sv
